FILE: hw/rtl/ntc_adc_to_temperature_top_assert.svh
// ============================================================================
// Assertion macros for the thermistor conversion block
// Clocked on clk, disabled while rst_n is low.
// ============================================================================
`ifndef NTC_ADC_TO_TEMPERATURE_TOP_ASSERT_SVH
`define NTC_ADC_TO_TEMPERATURE_TOP_ASSERT_SVH

// consequent must hold in the same cycle
`define NTC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the next cycle
`define NTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ntc_pkg.sv
// ============================================================================
// ntc_pkg
// Types, widths and constants shared by the thermistor conversion pipeline.
// ============================================================================
package ntc_pkg;

    // field widths
    localparam int SAMPLE_BITS = 12;
    localparam int CHAN_W      = 2;
    localparam int TEMP_W      = 16;
    localparam int BETA_W      = 14;
    localparam int OHMS_W      = 20;
    localparam int LIMIT_W     = 12;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 3;

    // divider full scale and divide guard, ceil(FULL*329/330)
    localparam int FULL_INT  = (1 << SAMPLE_BITS) - 1;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = SAMPLE_BITS'(FULL_INT);
    localparam logic [SAMPLE_BITS-1:0] DIV_GUARD  =
        SAMPLE_BITS'((FULL_INT * 329 + 329) / 330);

    // log2 datapath
    localparam int PROD_W = OHMS_W + SAMPLE_BITS;
    localparam int P_W    = $clog2(PROD_W);
    localparam int FRAC_W = 24;
    localparam int LOG_W  = P_W + FRAC_W;
    localparam int MANT_W = 31;                 // Q1.30

    // ln2 in Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // ln/beta division, Q0.40
    localparam int NUM1_W = LOG_W + 16;
    localparam int Q40_W  = NUM1_W;

    // inverse temperature, signed Q0.40
    localparam int INV_W = Q40_W + 2;
    localparam int MAG_W = Q40_W + 1;
    localparam logic signed [INV_W-1:0] INV_T0_Q40 =
        INV_W'((((64'd1) << 40) * 20 + 64'd2981) / 64'd5963);

    // 10*2^56 / inv, quotient kept to Q2_W bits, larger ones saturate
    localparam int NUM2_W = 60;
    localparam int Q2_W   = 33;
    localparam logic [NUM2_W-1:0] TEN_Q56 = NUM2_W'(64'd10 << 56);

    // final correction
    localparam int V_W = Q2_W + 3;
    localparam longint OFFSET_Q16 = 64'sd2731 * 64'sd65536;

    // result codes
    localparam logic signed [TEMP_W-1:0] INVALID_CODE = 16'sd32767;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX     = 16'sd32766;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN     = -16'sd32768;
    localparam logic signed [TEMP_W-1:0] ZERO_R_CODE  = -16'sd2731;

    // register reset values
    localparam logic [BETA_W-1:0]  BETA_RESET    = 14'd3950;
    localparam logic [OHMS_W-1:0]  NOMINAL_RESET = 20'd10000;
    localparam logic [OHMS_W-1:0]  SERIES_RESET  = 20'd10000;
    localparam logic [LIMIT_W-1:0] LOW_RESET     = 12'd100;
    localparam logic [LIMIT_W-1:0] HIGH_RESET    = 12'd3995;

    // pipeline latency
    localparam int LOG_LAT = 1 + FRAC_W;
    localparam int LATENCY = 1 + LOG_LAT + 2 + Q40_W + 3 + Q2_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BETA    = 3'd0,
        REG_NOMINAL = 3'd1,
        REG_SERIES  = 3'd2,
        REG_LOW     = 3'd3,
        REG_HIGH    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [CHAN_W-1:0]      channel;
    } ntc_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0]        channel_out;
        logic signed [TEMP_W-1:0] temp_dc;
        logic                     valid_res;
    } ntc_rsp_t;

    // per-item control travelling alongside the data
    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] channel;
        logic              bad;       // out of limits, guard, or zero beta
        logic              zero_r;    // R or ratio degenerate
        logic              neg;       // ln ratio negative
        logic              inv_neg;   // inverse temperature negative
        logic              inv_zero;  // inverse temperature exactly zero
        logic              sat;       // quotient beyond kept range
    } ntc_ctl_t;

endpackage

FILE: hw/rtl/ntc_adc_to_temperature_top.sv
// ============================================================================
// ntc_adc_to_temperature_top
// Thermistor divider sample to temperature in tenths of a degree Celsius,
// beta equation in fixed point, fully pipelined.
// ============================================================================
//
//  port group   dir  handshake             payload
//  req          in   req_valid/req_ready   ntc_req_t  (sample, channel)
//  rsp          out  rsp_valid/rsp_ready   ntc_rsp_t  (channel_out, temp, valid)
//  cfg          in   cfg_we                cfg_index, cfg_data
//
//  One sample accepted per cycle while the output is not stalled. Register stages:
//  1 input, 25 log2, 2 ln scaling, 45 for the beta divider, 3 inverse
//  temperature, 33 for the reciprocal divider, 2 output.
//  All stages advance together; when a result sits unaccepted in the
//  output register the whole pipeline holds and req_ready is low.
//  Reset clears the stage valid bits and loads the register defaults.
//
`include "ntc_adc_to_temperature_top_assert.svh"

module ntc_adc_to_temperature_top
    import ntc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  ntc_req_t              req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output ntc_rsp_t              rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic signed [V_W-1:0] OFF_V     = V_W'(OFFSET_Q16);
    localparam logic signed [V_W-1:0] OFF_M1_V  = V_W'(OFFSET_Q16 - 1);
    localparam logic signed [V_W-1:0] TRUNC_ADJ = V_W'(65535);
    localparam logic signed [V_W-1:0] MIN_V     = V_W'(TEMP_MIN);
    localparam logic signed [V_W-1:0] MAX_V     = V_W'(TEMP_MAX);

    logic [BETA_W-1:0]  beta_reg;
    logic [OHMS_W-1:0]  nominal_reg;
    logic [OHMS_W-1:0]  series_reg;
    logic [LIMIT_W-1:0] low_reg;
    logic [LIMIT_W-1:0] high_reg;

    logic en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg    <= BETA_RESET;
            nominal_reg <= NOMINAL_RESET;
            series_reg  <= SERIES_RESET;
            low_reg     <= LOW_RESET;
            high_reg    <= HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BETA:    beta_reg    <= cfg_data[BETA_W-1:0];
                REG_NOMINAL: nominal_reg <= cfg_data[OHMS_W-1:0];
                REG_SERIES:  series_reg  <= cfg_data[OHMS_W-1:0];
                REG_LOW:     low_reg     <= cfg_data[LIMIT_W-1:0];
                REG_HIGH:    high_reg    <= cfg_data[LIMIT_W-1:0];
                default:     ;
            endcase
        end
    end

    // global advance: output register free or being taken
    assign en        = !rsp_valid || rsp_ready;
    assign req_ready = en;

    // ---------------- input stage: products and checks ----------------
    ntc_ctl_t          ctl_s1_reg;
    ntc_ctl_t          ctl_s1_next;
    logic [PROD_W-1:0] a_s1_reg;
    logic [PROD_W-1:0] b_s1_reg;

    always_comb
    begin
        ctl_s1_next         = '0;
        ctl_s1_next.valid   = req_valid;
        ctl_s1_next.channel = req.channel;
        ctl_s1_next.bad     = (req.sample < low_reg) || (req.sample > high_reg) ||
                              (req.sample >= DIV_GUARD) || (beta_reg == '0);
        ctl_s1_next.zero_r  = (req.sample == '0) || (series_reg == '0) ||
                              (nominal_reg == '0) || (req.sample == FULL_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_s1_reg <= '0;
        else if (en)
            ctl_s1_reg <= ctl_s1_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_s1_reg <= PROD_W'(series_reg) * PROD_W'(req.sample);
            b_s1_reg <= PROD_W'(FULL_SCALE - req.sample) * PROD_W'(nominal_reg);
        end
    end

    // ---------------- log2 of both products ----------------
    ntc_ctl_t         ctl_l;
    logic [LOG_W-1:0] la;
    logic [LOG_W-1:0] lb;

    ntc_log2 u_log2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_s1_reg),
        .a_in    (a_s1_reg),
        .b_in    (b_s1_reg),
        .ctl_out (ctl_l),
        .la      (la),
        .lb      (lb)
    );

    // ---------------- log2 difference ----------------
    ntc_ctl_t         ctl_d_reg;
    ntc_ctl_t         ctl_d_next;
    logic [LOG_W-1:0] d_reg;
    logic             neg_next;

    assign neg_next = la < lb;

    always_comb
    begin
        ctl_d_next     = ctl_l;
        ctl_d_next.neg = neg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_d_reg <= '0;
        else if (en)
            ctl_d_reg <= ctl_d_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= neg_next ? (lb - la) : (la - lb);
    end

    // ---------------- times ln2, rounded ----------------
    ntc_ctl_t          ctl_m_reg;
    logic [LOG_W-1:0]  lnmag_reg;
    logic [LOG_W+31:0] ln_prod;

    assign ln_prod = (LOG_W+32)'(d_reg) * (LOG_W+32)'(LN2_Q32) + (LOG_W+32)'(33'h080000000);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_m_reg <= '0;
        else if (en)
            ctl_m_reg <= ctl_d_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lnmag_reg <= ln_prod[LOG_W+31:32];
    end

    // ---------------- ln / beta in Q0.40 ----------------
    ntc_ctl_t         ctl_q1;
    logic [Q40_W-1:0] q40;

    ntc_div #(
        .N_W (NUM1_W),
        .D_W (BETA_W),
        .Q_W (Q40_W)
    ) u_div_beta (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_m_reg),
        .num_in  ({lnmag_reg, 16'h0000}),
        .den_in  (beta_reg),
        .ctl_out (ctl_q1),
        .quo     (q40)
    );

    // ---------------- inverse temperature ----------------
    ntc_ctl_t                ctl_i1_reg;
    logic signed [INV_W-1:0] inv_reg;
    logic signed [INV_W-1:0] q40_s;

    assign q40_s = $signed({2'b00, q40});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_i1_reg <= '0;
        else if (en)
            ctl_i1_reg <= ctl_q1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            inv_reg <= ctl_q1.neg ? (INV_T0_Q40 - q40_s) : (INV_T0_Q40 + q40_s);
    end

    // magnitude and sign
    ntc_ctl_t         ctl_i2_reg;
    ntc_ctl_t         ctl_i2_next;
    logic [MAG_W-1:0] mag_i2_reg;
    logic signed [INV_W-1:0] inv_negated;

    assign inv_negated = -inv_reg;

    always_comb
    begin
        ctl_i2_next          = ctl_i1_reg;
        ctl_i2_next.inv_neg  = inv_reg[INV_W-1];
        ctl_i2_next.inv_zero = (inv_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_i2_reg <= '0;
        else if (en)
            ctl_i2_reg <= ctl_i2_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            mag_i2_reg <= inv_reg[INV_W-1] ? inv_negated[MAG_W-1:0] : inv_reg[MAG_W-1:0];
    end

    // saturation: quotient would need more than Q2_W bits
    ntc_ctl_t         ctl_i3_reg;
    ntc_ctl_t         ctl_i3_next;
    logic [MAG_W-1:0] mag_i3_reg;
    logic             sat_next;

    assign sat_next = (MAG_W+Q2_W)'(TEN_Q56) >= {mag_i2_reg, {Q2_W{1'b0}}};

    always_comb
    begin
        ctl_i3_next     = ctl_i2_reg;
        ctl_i3_next.sat = sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_i3_reg <= '0;
        else if (en)
            ctl_i3_reg <= ctl_i3_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            mag_i3_reg <= mag_i2_reg;
    end

    // ---------------- 10*2^56 / |inv| ----------------
    ntc_ctl_t        ctl_q2;
    logic [Q2_W-1:0] q2;

    ntc_div #(
        .N_W (NUM2_W),
        .D_W (MAG_W),
        .Q_W (Q2_W)
    ) u_div_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_i3_reg),
        .num_in  (TEN_Q56),
        .den_in  (mag_i3_reg),
        .ctl_out (ctl_q2),
        .quo     (q2)
    );

    // ---------------- apply sign, subtract 273.1 ----------------
    ntc_ctl_t              ctl_f1_reg;
    logic signed [V_W-1:0] v_reg;
    logic signed [V_W-1:0] q_ext;

    assign q_ext = $signed(V_W'(q2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_f1_reg <= '0;
        else if (en)
            ctl_f1_reg <= ctl_q2;
    end

    // -q - OFF written as ~q - (OFF - 1)
    always_ff @(posedge clk)
    begin
        if (en)
            v_reg <= ctl_q2.inv_neg ? ((~q_ext) - OFF_M1_V) : (q_ext - OFF_V);
    end

    // ---------------- truncate, clamp, output register ----------------
    logic signed [V_W-1:0]    t_next;
    logic signed [TEMP_W-1:0] temp_next;
    ntc_rsp_t                 rsp_reg;
    ntc_rsp_t                 rsp_next;
    logic                     rsp_valid_reg;

    // shift toward zero
    assign t_next = v_reg[V_W-1] ? ((v_reg + TRUNC_ADJ) >>> 16) : (v_reg >>> 16);

    always_comb
    begin
        if (ctl_f1_reg.bad)
            temp_next = INVALID_CODE;
        else if (ctl_f1_reg.zero_r)
            temp_next = ZERO_R_CODE;
        else if (ctl_f1_reg.inv_zero)
            temp_next = TEMP_MAX;
        else if (ctl_f1_reg.sat)
            temp_next = ctl_f1_reg.inv_neg ? TEMP_MIN : TEMP_MAX;
        else if (t_next < MIN_V)
            temp_next = TEMP_MIN;
        else if (t_next > MAX_V)
            temp_next = TEMP_MAX;
        else
            temp_next = t_next[TEMP_W-1:0];

        rsp_next.channel_out = ctl_f1_reg.channel;
        rsp_next.temp_dc     = temp_next;
        rsp_next.valid_res   = !ctl_f1_reg.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (en)
            rsp_valid_reg <= ctl_f1_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- checks ----------------
    `NTC_ASSERT_SAME(a_invalid_code, rsp_valid && !rsp.valid_res,
        rsp.temp_dc == INVALID_CODE, "invalid result without invalid code")
    `NTC_ASSERT_SAME(a_valid_code, rsp_valid && rsp.valid_res,
        rsp.temp_dc != INVALID_CODE, "valid result carries invalid code")
    `NTC_ASSERT_SAME(a_stall_back, rsp_valid && !rsp_ready,
        !req_ready, "input taken while output stalled")
    `NTC_ASSERT_NEXT(a_entry, req_valid && req_ready,
        ctl_s1_reg.valid && (ctl_s1_reg.channel == $past(req.channel)),
        "accepted sample missing from first stage")

endmodule

FILE: hw/rtl/ntc_log2.sv
// ============================================================================
// ntc_log2
// Dual log2 unit: leading-one normalise, then one squaring stage per
// fraction bit. Result is unsigned Q(P_W).24 for both operands.
// ============================================================================
module ntc_log2
    import ntc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  ntc_ctl_t          ctl_in,
    input  logic [PROD_W-1:0] a_in,
    input  logic [PROD_W-1:0] b_in,
    output ntc_ctl_t          ctl_out,
    output logic [LOG_W-1:0]  la,
    output logic [LOG_W-1:0]  lb
);

    // position of the leading one (0 for zero)
    function automatic logic [P_W-1:0] lead_pos(input logic [PROD_W-1:0] x);
        logic [P_W-1:0] p;
        p = '0;
        for (int i = 0; i < PROD_W; i++)
        begin
            if (x[i])
                p = P_W'(i);
        end
        return p;
    endfunction

    // mantissa in Q1.30, low bits truncated
    function automatic logic [MANT_W-1:0] normalise(input logic [PROD_W-1:0] x,
                                                     input logic [P_W-1:0] p);
        logic [PROD_W+MANT_W-1:0] w;
        w = (PROD_W+MANT_W)'(x) << (MANT_W - 1);
        w = w >> p;
        return w[MANT_W-1:0];
    endfunction

    // one squaring step: {fraction bit, new mantissa}
    function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     t;
        sq = (2*MANT_W)'(m) * (2*MANT_W)'(m);
        t  = sq[2*MANT_W-1:MANT_W-1];
        if (t[MANT_W])
            return {1'b1, t[MANT_W:1]};
        else
            return {1'b0, t[MANT_W-1:0]};
    endfunction

    ntc_ctl_t          ctl_reg [0:FRAC_W];
    logic [MANT_W-1:0] ma_reg  [0:FRAC_W];
    logic [MANT_W-1:0] mb_reg  [0:FRAC_W];
    logic [LOG_W-1:0]  ra_reg  [0:FRAC_W];
    logic [LOG_W-1:0]  rb_reg  [0:FRAC_W];

    logic [P_W-1:0] pa_next;
    logic [P_W-1:0] pb_next;

    // normalise stage
    assign pa_next = lead_pos(a_in);
    assign pb_next = lead_pos(b_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[0] <= '0;
        else if (en)
            ctl_reg[0] <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg[0] <= normalise(a_in, pa_next);
            mb_reg[0] <= normalise(b_in, pb_next);
            ra_reg[0] <= {pa_next, {FRAC_W{1'b0}}};
            rb_reg[0] <= {pb_next, {FRAC_W{1'b0}}};
        end
    end

    // squaring stages, stage k yields fraction bit FRAC_W-k
    for (genvar k = 1; k <= FRAC_W; k++)
    begin : g_sq
        logic [MANT_W:0] sa_next;
        logic [MANT_W:0] sb_next;

        assign sa_next = sq_step(ma_reg[k-1]);
        assign sb_next = sq_step(mb_reg[k-1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[k] <= '0;
            else if (en)
                ctl_reg[k] <= ctl_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ma_reg[k] <= sa_next[MANT_W-1:0];
                mb_reg[k] <= sb_next[MANT_W-1:0];
                ra_reg[k] <= ra_reg[k-1] | (LOG_W'(sa_next[MANT_W]) << (FRAC_W - k));
                rb_reg[k] <= rb_reg[k-1] | (LOG_W'(sb_next[MANT_W]) << (FRAC_W - k));
            end
        end
    end

    assign ctl_out = ctl_reg[FRAC_W];
    assign la      = ra_reg[FRAC_W];
    assign lb      = rb_reg[FRAC_W];

endmodule

FILE: hw/rtl/ntc_div.sv
// ============================================================================
// ntc_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Needs num_in < den_in * 2^Q_W for an exact quotient.
// ============================================================================
module ntc_div
    import ntc_pkg::*;
#(
    parameter int N_W = NUM1_W,
    parameter int D_W = BETA_W,
    parameter int Q_W = Q40_W
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  ntc_ctl_t       ctl_in,
    input  logic [N_W-1:0] num_in,
    input  logic [D_W-1:0] den_in,
    output ntc_ctl_t       ctl_out,
    output logic [Q_W-1:0] quo
);

    localparam int CW = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

    ntc_ctl_t       ctl_reg [1:Q_W];
    logic [N_W-1:0] rem_reg [1:Q_W];
    logic [D_W-1:0] den_reg [1:Q_W];
    logic [Q_W-1:0] quo_reg [1:Q_W];

    for (genvar i = 1; i <= Q_W; i++)
    begin : g_stage
        ntc_ctl_t       ctl_src;
        logic [N_W-1:0] rem_src;
        logic [D_W-1:0] den_src;
        logic [Q_W-1:0] quo_src;
        logic [CW-1:0]  trial;
        logic           ge;
        logic [N_W-1:0] rem_next;

        if (i == 1)
        begin : g_first
            assign ctl_src = ctl_in;
            assign rem_src = num_in;
            assign den_src = den_in;
            assign quo_src = '0;
        end
        else
        begin : g_rest
            assign ctl_src = ctl_reg[i-1];
            assign rem_src = rem_reg[i-1];
            assign den_src = den_reg[i-1];
            assign quo_src = quo_reg[i-1];
        end

        // trial subtract of the divisor at bit Q_W-i
        assign trial    = CW'(den_src) << (Q_W - i);
        assign ge       = CW'(rem_src) >= trial;
        assign rem_next = ge ? N_W'(CW'(rem_src) - trial) : rem_src;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i] <= '0;
            else if (en)
                ctl_reg[i] <= ctl_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_src;
                quo_reg[i] <= (quo_src << 1) | Q_W'(ge);
            end
        end
    end

    assign ctl_out = ctl_reg[Q_W];
    assign quo     = quo_reg[Q_W];

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: thermistor sample to temperature testbench
// Streams divider samples through the conversion pipeline under several
// register settings and handshake patterns. Every output transfer is checked
// field by field against a fixed-point predictor of the beta equation.
// ----------------------------------------------------------------------------
module tb_top;
    import ntc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint unsigned INV_T0 = ((64'd1 << 40) * 20 + 64'd2981) / 64'd5963;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    ntc_req_t              req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    ntc_rsp_t              rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // register copies
    logic [BETA_W-1:0]  beta_k;
    logic [OHMS_W-1:0]  nominal_r;
    logic [OHMS_W-1:0]  series_ohm;
    logic [LIMIT_W-1:0] low_lim;
    logic [LIMIT_W-1:0] high_lim;

    ntc_req_t sample_queue[$];
    ntc_rsp_t temp_queue[$];

    int  idle_pct;
    int  stall_pct;
    int  hold_cycles;
    int  errors;
    int  quiet_cycles;
    bit  req_taken;

    ntc_adc_to_temperature_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // log2 in unsigned Q6.24, leading one then repeated squaring
    function automatic longint unsigned log2_fix(longint unsigned x);
        int p;
        int i;
        longint unsigned m;
        longint unsigned r;
        p = 63;
        while (p > 0 && x[p] == 1'b0)
            p--;
        if (p >= 30)
            m = x >> (p - 30);
        else
            m = x << (30 - p);
        r = longint'(p) << 24;
        for (i = 23; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    // temperature in tenths for an in-range sample
    function automatic longint calc_tenths(longint unsigned s);
        longint unsigned a, b, la, lb, d, lnmag, q40mag, mag;
        bit neg;
        longint inv, q, v;
        a = longint'(series_ohm) * s;
        b = (longint'(FULL_INT) - s) * longint'(nominal_r);
        if (a == 0 || b == 0)
            return -2731;
        la = log2_fix(a);
        lb = log2_fix(b);
        neg = la < lb;
        d = neg ? (lb - la) : (la - lb);
        lnmag = (d * 64'd2977044472 + 64'h8000_0000) >> 32;
        q40mag = (lnmag << 16) / longint'(beta_k);
        inv = neg ? longint'(INV_T0) - longint'(q40mag) : longint'(INV_T0) + longint'(q40mag);
        if (inv == 0)
            return 32766;
        mag = (inv < 0) ? longint'(-inv) : longint'(inv);
        q = longint'((64'd10 << 56) / mag);
        if (inv < 0)
            q = -q;
        v = q - 64'sd2731 * 64'sd65536;
        if (v >= 0)
            v = v >>> 16;
        else
            v = -((-v) >>> 16);
        if (v < -32768)
            v = -32768;
        if (v > 32766)
            v = 32766;
        return v;
    endfunction

    function automatic ntc_rsp_t convert_sample(ntc_req_t item);
        ntc_rsp_t r;
        bit ok;
        ok = !(item.sample < low_lim || item.sample > high_lim ||
               item.sample >= DIV_GUARD || beta_k == 0);
        r.channel_out = item.channel;
        r.temp_dc     = ok ? 16'(calc_tenths(item.sample)) : 16'sd32767;
        r.valid_res   = ok;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver: record the transfer at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
        begin
            temp_queue.push_back(convert_sample(sample_queue.pop_front()));
            req_taken = 1'b1;
        end
    end

    // driver: offer the next item at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (req_taken || !req_valid)
        begin
            req_taken = 1'b0;
            if (sample_queue.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                req_valid <= 1'b1;
                req       <= sample_queue[0];
            end
            else
                req_valid <= 1'b0;
        end
    end

    // receiver stall pattern, with a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (temp_queue.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                ntc_rsp_t want;
                want = temp_queue.pop_front();
                if (rsp.channel_out !== want.channel_out)
                    report_mismatch("channel_out", rsp.channel_out, want.channel_out);
                if (rsp.temp_dc !== want.temp_dc)
                    report_mismatch("temp_dc", rsp.temp_dc, want.temp_dc);
                if (rsp.valid_res !== want.valid_res)
                    report_mismatch("valid_res", rsp.valid_res, want.valid_res);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_BETA:    beta_k     = val[BETA_W-1:0];
            REG_NOMINAL: nominal_r  = val;
            REG_SERIES:  series_ohm = val;
            REG_LOW:     low_lim    = val[LIMIT_W-1:0];
            REG_HIGH:    high_lim   = val[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int beta, int nom, int ser, int lo, int hi);
        write_reg(REG_BETA, CFG_DATA_W'(beta));
        write_reg(REG_NOMINAL, CFG_DATA_W'(nom));
        write_reg(REG_SERIES, CFG_DATA_W'(ser));
        write_reg(REG_LOW, CFG_DATA_W'(lo));
        write_reg(REG_HIGH, CFG_DATA_W'(hi));
    endtask

    task automatic add_sample(int s, int ch);
        ntc_req_t item;
        item.sample  = SAMPLE_BITS'(s);
        item.channel = CHAN_W'(ch);
        sample_queue.push_back(item);
    endtask

    // mostly in-range samples, the rest over the whole field
    task automatic add_random(int n);
        int lo;
        int hi;
        lo = (low_lim <= high_lim) ? int'(low_lim) : 0;
        hi = (low_lim <= high_lim) ? int'(high_lim) : FULL_INT;
        repeat (n)
        begin
            if ($urandom_range(99) < 80)
                add_sample($urandom_range(hi, lo), $urandom_range(3));
            else
                add_sample($urandom_range(FULL_INT), $urandom_range(3));
        end
    endtask

    // wait until every sample is sent and every result is back, then let the pipe drain
    task automatic wait_drained();
        wait (sample_queue.size() == 0 && !req_valid && temp_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic run_phase(int n, int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        add_random(n);
        wait_drained();
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0; req_valid = 1'b0; req = '0; rsp_ready = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        idle_pct = 0; stall_pct = 0; hold_cycles = 0; errors = 0;
        quiet_cycles = 0; req_taken = 1'b0;
        beta_k = BETA_RESET; nominal_r = NOMINAL_RESET; series_ohm = SERIES_RESET;
        low_lim = LOW_RESET; high_lim = HIGH_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: limits, divide guard, extremes, every channel
        add_sample(0, 0);     add_sample(99, 1);    add_sample(100, 2);
        add_sample(101, 3);   add_sample(2048, 0);  add_sample(3995, 1);
        add_sample(3996, 2);  add_sample(4082, 3);  add_sample(4083, 0);
        add_sample(4095, 3);
        wait_drained();
        // wide limits: zero sample, guard edge; unknown indexes ignored
        set_regs(1000, 100, 1000000, 0, 4095);
        write_reg(cfg_reg_t'(5), 20'hFFFFF);
        write_reg(cfg_reg_t'(7), 20'h0);
        add_sample(0, 1); add_sample(1, 2); add_sample(4082, 3); add_sample(4083, 0);
        add_sample(10, 1); add_sample(4000, 2);
        wait_drained();
        // zero beta, then zero nominal and zero series
        set_regs(0, 10000, 10000, 0, 4095);
        add_sample(2000, 1);
        wait_drained();
        set_regs(3950, 0, 0, 0, 4095);
        add_sample(1, 2); add_sample(3000, 3);
        wait_drained();
        // all-ones data, masked to each register width; low above high
        set_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'h00000);
        add_sample(0, 0); add_sample(4095, 3);
        wait_drained();

        // random: defaults, no idling
        set_regs(3950, 10000, 10000, 100, 3995);
        run_phase(250, 0, 0);
        // extremes of the legal ranges, sender idling, then receiver stalling
        set_regs(1000, 1000000, 100, 0, 4095);
        run_phase(200, 59, 0);
        set_regs(10000, 100, 1000000, 0, 4095);
        run_phase(200, 0, 59);
        // long receiver hold-off while the sender keeps offering
        set_regs(3435, 47000, 22000, 50, 4050);
        hold_cycles = 400;
        run_phase(250, 0, 0);
        // random settings, both sides idling
        for (k = 0; k < 6; k++)
        begin
            set_regs($urandom_range(10000, 1000), $urandom_range(1000000, 100),
                     $urandom_range(1000000, 100), $urandom_range(300),
                     $urandom_range(4095, 3800));
            run_phase(100, (k % 2) ? 7 : 59, (k % 2) ? 7 : 59);
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
